@@ rtl/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// Priority task scheduler package
// Shared constants, codes and transaction types of the task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int MAX_TASKS  = 16;
	localparam int PRIO_BITS  = 8;
	localparam int TIME_BITS  = 32;
	localparam int STAMP_BITS = 32;
	localparam int IDX_W      = $clog2(MAX_TASKS);

	typedef enum logic [1:0] {
		FUNC_CREATE = 2'd0,
		FUNC_READY  = 2'd1,
		FUNC_TICK   = 2'd2,
		FUNC_SWITCH = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		RSN_READY = 2'd0,
		RSN_BUSY  = 2'd1,
		RSN_SYNC  = 2'd2,
		RSN_SLEEP = 2'd3
	} reason_t;

	typedef enum logic [1:0] {
		TAG_NONE   = 2'd0,
		TAG_LIST_A = 2'd1,
		TAG_LIST_B = 2'd2,
		TAG_BUSY   = 2'd3
	} tag_t;

	typedef enum logic [1:0] {
		M_BUSY,
		M_SLEEP,
		M_PEND
	} scan_mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_APPLY,
		S_DONE
	} state_t;

	typedef struct packed {
		func_t       func;
		logic [3:0]  task_id;
		logic [7:0]  task_priority_in;
		reason_t     switch_reason;
		logic [31:0] time_value;
		logic        sleep_forever;
	} cmd_t;

	typedef struct packed {
		logic [3:0] next_task;
		logic       next_is_idle;
		logic       preempt;
	} res_t;

	typedef struct packed {
		tag_t                  tag;
		logic                  delayed;
		logic [PRIO_BITS-1:0]  prio;
		logic [STAMP_BITS-1:0] age;
		logic [TIME_BITS-1:0]  wake;
	} cand_t;

	typedef struct packed {
		logic                  valid;
		logic [PRIO_BITS-1:0]  prio;
		logic [STAMP_BITS-1:0] age;
		logic [TIME_BITS-1:0]  wake;
	} best_t;

endpackage

@@ rtl/pts_cmp.sv @@
// ----------------------------------------------------------------------------
// Scan comparator
// Decides whether the scanned task entry replaces the best one found so far.
// ----------------------------------------------------------------------------
module pts_cmp (
	input  pts_pkg::scan_mode_t                  mode,
	input  pts_pkg::tag_t                        target,
	input  logic [pts_pkg::TIME_BITS-1:0]        now,
	input  pts_pkg::cand_t                       cand,
	input  pts_pkg::best_t                       best,
	output logic                                 take
);
	import pts_pkg::*;

	logic eligible;
	logic better;

	always_comb begin
		if (mode == M_SLEEP) begin
			eligible = cand.delayed && (cand.wake <= now);
		end else begin
			eligible = (cand.tag == target);
		end
	end

	always_comb begin
		better = 1'b0;
		if (!best.valid) begin
			better = 1'b1;
		end else begin
			case (mode)
				M_SLEEP: better = (cand.wake < best.wake) ||
					((cand.wake == best.wake) && (cand.age > best.age));
				M_PEND: begin
					if (cand.prio != best.prio) begin
						better = cand.prio > best.prio;
					end else begin
						better = cand.age > best.age;
					end
				end
				default: better = cand.age > best.age;
			endcase
		end
	end

	assign take = eligible && better;

endmodule

@@ rtl/priority_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// Priority task scheduler
// Task table with ready, pending and busy lists and a delay queue.
// ----------------------------------------------------------------------------
// Commands arrive on the cmd channel (cmd_valid/cmd_ready, payload cmd) and
// each produces exactly one transaction on the res channel (res_valid/
// res_ready, payload res). The block takes one command at a time; cmd_ready
// is high only while no command is in work.
// Create and ready need no list search. Every list search
// walks the task table one entry a cycle through a single shared comparator.
// A context switch searches the pending list and, if it is empty, swaps pending
// and ready and searches once more. A tick moves one busy task per pass to the
// ready list until none is left, then the due sleepers, earliest wake first.
// The next command can be accepted in the cycle after a result is loaded.
// Reset leaves all tasks on no list and out of the delay queue with the idle
// task running. A result waits in the output register while res_ready is low;
// the next command may be accepted meanwhile but is not finished until the
// output register is free.
// ----------------------------------------------------------------------------
module priority_task_scheduler (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  pts_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output pts_pkg::res_t res
);
	import pts_pkg::*;

	logic [PRIO_BITS-1:0]  prio_q    [MAX_TASKS];
	tag_t                  tag_q     [MAX_TASKS];
	logic [STAMP_BITS-1:0] stamp_q   [MAX_TASKS];
	logic                  delayed_q [MAX_TASKS];
	logic [TIME_BITS-1:0]  wake_q    [MAX_TASKS];

	state_t                state_q, state_d;
	scan_mode_t            mode_q;
	cmd_t                  cmd_q;
	logic [STAMP_BITS-1:0] counter_q;
	logic                  pend_sel_q;
	logic [IDX_W-1:0]      run_task_q;
	logic                  run_idle_q;
	logic [PRIO_BITS-1:0]  run_prio_q;
	logic                  first_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      best_idx_q;
	best_t                 best_q;
	logic [3:0]            next_q;
	logic                  idle_q;
	logic                  yield_q;
	logic                  res_valid_q;
	res_t                  res_q;

	tag_t                  ready_tag, pend_tag, target;
	logic [IDX_W-1:0]      rd_idx, cmd_idx;
	logic [PRIO_BITS-1:0]  new_prio, mk_prio;
	logic [TIME_BITS-1:0]  tval;
	cand_t                 cand;
	logic                  take;
	logic                  in_range, last_idx, out_free;
	logic                  mk_ready, set_prio, refile, scan_clr, take_head;
	logic                  toggle_sel, go_idle, yield_set;
	logic [IDX_W-1:0]      mk_idx;
	logic                  as_ready, rf_stamp;

	assign ready_tag = pend_sel_q ? TAG_LIST_B : TAG_LIST_A;
	assign pend_tag  = pend_sel_q ? TAG_LIST_A : TAG_LIST_B;
	assign target    = (mode_q == M_BUSY) ? TAG_BUSY : pend_tag;
	assign cmd_idx   = IDX_W'(cmd_q.task_id);
	assign rd_idx    = (state_q == S_EXEC) ? cmd_idx : idx_q;
	assign new_prio  = PRIO_BITS'(cmd_q.task_priority_in);
	assign tval      = TIME_BITS'(cmd_q.time_value);
	assign in_range  = int'(cmd_q.task_id) < MAX_TASKS;
	assign last_idx  = idx_q == IDX_W'(MAX_TASKS - 1);
	assign out_free  = !res_valid_q || res_ready;

	assign cand.tag     = tag_q[rd_idx];
	assign cand.delayed = delayed_q[rd_idx];
	assign cand.prio    = prio_q[rd_idx];
	assign cand.age     = counter_q - stamp_q[rd_idx];
	assign cand.wake    = wake_q[rd_idx];

	pts_cmp u_cmp (
		.mode   (mode_q),
		.target (target),
		.now    (tval),
		.cand   (cand),
		.best   (best_q),
		.take   (take)
	);

	assign as_ready = (cmd_q.switch_reason == RSN_READY) ||
		((cmd_q.switch_reason == RSN_SLEEP) && !cmd_q.sleep_forever && (tval == '0));
	assign rf_stamp = as_ready || (cmd_q.switch_reason == RSN_BUSY) ||
		((cmd_q.switch_reason == RSN_SLEEP) && !cmd_q.sleep_forever);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (cmd_valid) state_d = S_EXEC;
			S_EXEC: begin
				if (cmd_q.func == FUNC_CREATE || cmd_q.func == FUNC_READY) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN:  if (last_idx) state_d = S_APPLY;
			S_APPLY: begin
				unique case (mode_q)
					M_BUSY:  state_d = S_SCAN;
					M_SLEEP: state_d = best_q.valid ? S_SCAN : S_DONE;
					default: state_d = (!best_q.valid && first_q) ? S_SCAN : S_DONE;
				endcase
			end
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mk_ready   = 1'b0;
		mk_idx     = best_idx_q;
		mk_prio    = best_q.prio;
		set_prio   = 1'b0;
		refile     = 1'b0;
		scan_clr   = 1'b0;
		take_head  = 1'b0;
		toggle_sel = 1'b0;
		go_idle    = 1'b0;
		yield_set  = 1'b0;
		unique case (state_q)
			S_EXEC: begin
				unique case (cmd_q.func)
					FUNC_CREATE, FUNC_READY: begin
						mk_ready = in_range;
						mk_idx   = cmd_idx;
						set_prio = in_range && (cmd_q.func == FUNC_CREATE);
						mk_prio  = (cmd_q.func == FUNC_CREATE) ? new_prio : cand.prio;
						yield_set = in_range && (cmd_q.func == FUNC_READY) &&
							(run_idle_q || (mk_prio > run_prio_q));
					end
					FUNC_TICK: scan_clr = 1'b1;
					default: begin
						refile   = !run_idle_q;
						scan_clr = 1'b1;
					end
				endcase
			end
			S_APPLY: begin
				if (mode_q == M_PEND) begin
					if (best_q.valid) begin
						take_head = 1'b1;
					end else if (first_q) begin
						toggle_sel = 1'b1;
						scan_clr   = 1'b1;
					end else begin
						go_idle = 1'b1;
					end
				end else begin
					mk_ready  = best_q.valid;
					yield_set = best_q.valid && (run_idle_q || (best_q.prio > run_prio_q));
					scan_clr  = best_q.valid || (mode_q == M_BUSY);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= M_BUSY;
			counter_q   <= '0;
			pend_sel_q  <= 1'b0;
			run_task_q  <= '0;
			run_idle_q  <= 1'b1;
			first_q     <= 1'b0;
			idx_q       <= '0;
			best_q      <= '0;
			best_idx_q  <= '0;
			next_q      <= '0;
			idle_q      <= 1'b0;
			yield_q     <= 1'b0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < MAX_TASKS; i++) begin
				tag_q[i]     <= TAG_NONE;
				stamp_q[i]   <= '0;
				delayed_q[i] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && cmd_valid) begin
				next_q  <= '0;
				idle_q  <= 1'b0;
				yield_q <= 1'b0;
			end
			if (state_q == S_EXEC) begin
				mode_q  <= (cmd_q.func == FUNC_TICK) ? M_BUSY : M_PEND;
				first_q <= 1'b1;
			end
			if (state_q == S_APPLY && mode_q == M_BUSY && !best_q.valid) begin
				mode_q <= M_SLEEP;
			end
			if (yield_set) yield_q <= 1'b1;
			if (mk_ready) begin
				delayed_q[mk_idx] <= 1'b0;
				tag_q[mk_idx]     <= ready_tag;
				stamp_q[mk_idx]   <= counter_q;
				counter_q         <= counter_q + 1'b1;
			end
			if (refile) begin
				if (as_ready) begin
					tag_q[run_task_q] <= ready_tag;
				end else if (cmd_q.switch_reason == RSN_BUSY) begin
					tag_q[run_task_q] <= TAG_BUSY;
				end else begin
					tag_q[run_task_q] <= TAG_NONE;
					if (rf_stamp) delayed_q[run_task_q] <= 1'b1;
				end
				if (rf_stamp) begin
					stamp_q[run_task_q] <= counter_q;
					counter_q           <= counter_q + 1'b1;
				end
			end
			if (scan_clr) begin
				idx_q        <= '0;
				best_q.valid <= 1'b0;
			end else if (state_q == S_SCAN) begin
				idx_q <= idx_q + 1'b1;
				if (take) begin
					best_q.valid <= 1'b1;
					best_q.prio  <= cand.prio;
					best_q.age   <= cand.age;
					best_q.wake  <= cand.wake;
					best_idx_q   <= idx_q;
				end
			end
			if (toggle_sel) begin
				pend_sel_q <= !pend_sel_q;
				first_q    <= 1'b0;
			end
			if (take_head) begin
				tag_q[best_idx_q] <= TAG_NONE;
				run_task_q        <= best_idx_q;
				run_idle_q        <= 1'b0;
				next_q            <= 4'(best_idx_q);
			end
			if (go_idle) begin
				run_idle_q <= 1'b1;
				idle_q     <= 1'b1;
			end
			if (state_q == S_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) cmd_q <= cmd;
		if (set_prio) prio_q[mk_idx] <= new_prio;
		if (refile && !as_ready && rf_stamp && (cmd_q.switch_reason == RSN_SLEEP)) begin
			wake_q[run_task_q] <= tval;
		end
		if (take_head) begin
			run_prio_q <= best_q.prio;
		end else if (set_prio && (mk_idx == run_task_q)) begin
			run_prio_q <= new_prio;
		end
		if (state_q == S_DONE && out_free) begin
			res_q.next_task    <= next_q;
			res_q.next_is_idle <= idle_q;
			res_q.preempt      <= yield_q;
		end
	end

	assign cmd_ready = state_q == S_IDLE;
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ verif/priority_task_scheduler_tb.sv @@
// ----------------------------------------------------------------------------
// Priority task scheduler testbench
// Drives scheduler commands with random idling on both channels and checks
// every result against a behavioral model of the task lists and delay queue.
// ----------------------------------------------------------------------------
module priority_task_scheduler_tb;

	import pts_pkg::*;

	localparam int N_RANDOM = 500;

	typedef struct {
		cmd_t c;
		logic chk;
		res_t r;
	} row_t;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic res_valid;
	logic res_ready;
	res_t res;

	logic [7:0]  sch_prio  [MAX_TASKS];
	tag_t        sch_tag   [MAX_TASKS];
	logic [31:0] sch_stamp [MAX_TASKS];
	logic        sch_dly   [MAX_TASKS];
	logic [31:0] sch_wake  [MAX_TASKS];
	logic        sch_made  [MAX_TASKS];
	logic [31:0] sch_count;
	logic        sch_sel;
	logic [3:0]  sch_run;
	logic        sch_idle;

	res_t expected_q[$];
	int   errors;
	int   n_results;
	int   send_gap;
	int   recv_gap;
	logic hold_off;
	row_t dir_rows[$];

	priority_task_scheduler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic tag_t ready_list();
		return sch_sel ? TAG_LIST_B : TAG_LIST_A;
	endfunction

	function automatic tag_t pend_list();
		return sch_sel ? TAG_LIST_A : TAG_LIST_B;
	endfunction

	function automatic logic [31:0] age(int t);
		return sch_count - sch_stamp[t];
	endfunction

	function automatic int run_prio();
		return sch_idle ? -1 : int'(sch_prio[sch_run]);
	endfunction

	function automatic logic file_ready(int t);
		sch_dly[t]   = 1'b0;
		sch_tag[t]   = ready_list();
		sch_stamp[t] = sch_count;
		sch_count++;
		return int'(sch_prio[t]) > run_prio();
	endfunction

	function automatic int head_of(tag_t tg, logic by_prio);
		int b;
		b = -1;
		for (int t = 0; t < MAX_TASKS; t++) begin
			if (sch_tag[t] != tg) continue;
			if (b < 0) b = t;
			else if (by_prio && sch_prio[t] != sch_prio[b]) begin
				if (sch_prio[t] > sch_prio[b]) b = t;
			end else if (age(t) > age(b)) b = t;
		end
		return b;
	endfunction

	function automatic int first_due(logic [31:0] now);
		int b;
		b = -1;
		for (int t = 0; t < MAX_TASKS; t++) begin
			if (!sch_dly[t] || sch_wake[t] > now) continue;
			if (b < 0 || sch_wake[t] < sch_wake[b] ||
			    (sch_wake[t] == sch_wake[b] && age(t) > age(b))) b = t;
		end
		return b;
	endfunction

	function automatic void sched_reset();
		for (int t = 0; t < MAX_TASKS; t++) begin
			sch_prio[t] = '0; sch_tag[t] = TAG_NONE; sch_stamp[t] = '0;
			sch_dly[t] = 1'b0; sch_wake[t] = '0; sch_made[t] = 1'b0;
		end
		sch_count = '0; sch_sel = 1'b0; sch_run = '0; sch_idle = 1'b1;
	endfunction

	function automatic res_t schedule(cmd_t c);
		res_t r;
		int t;
		int h;
		logic y;
		r = '0;
		case (c.func)
			FUNC_CREATE, FUNC_READY: begin
				t = int'(c.task_id);
				if (c.func == FUNC_CREATE) begin
					sch_prio[t] = c.task_priority_in;
					sch_made[t] = 1'b1;
				end
				y = file_ready(t);
				if (c.func == FUNC_READY) r.preempt = y;
			end
			FUNC_TICK: begin
				t = head_of(TAG_BUSY, 1'b0);
				while (t >= 0) begin
					if (file_ready(t)) r.preempt = 1'b1;
					t = head_of(TAG_BUSY, 1'b0);
				end
				t = first_due(c.time_value);
				while (t >= 0) begin
					if (file_ready(t)) r.preempt = 1'b1;
					t = first_due(c.time_value);
				end
			end
			default: begin
				if (!sch_idle) begin
					t = int'(sch_run);
					if (c.switch_reason == RSN_READY || (c.switch_reason == RSN_SLEEP &&
					    !c.sleep_forever && c.time_value == 0)) begin
						sch_tag[t] = ready_list();
						sch_stamp[t] = sch_count; sch_count++;
					end else if (c.switch_reason == RSN_BUSY) begin
						sch_tag[t] = TAG_BUSY;
						sch_stamp[t] = sch_count; sch_count++;
					end else begin
						sch_tag[t] = TAG_NONE;
						if (c.switch_reason == RSN_SLEEP && !c.sleep_forever) begin
							sch_dly[t] = 1'b1;
							sch_wake[t] = c.time_value;
							sch_stamp[t] = sch_count; sch_count++;
						end
					end
				end
				if (head_of(pend_list(), 1'b1) < 0) sch_sel = ~sch_sel;
				h = head_of(pend_list(), 1'b1);
				if (h < 0) begin
					sch_idle = 1'b1;
					r.next_is_idle = 1'b1;
				end else begin
					sch_tag[h] = TAG_NONE;
					sch_run = 4'(h);
					sch_idle = 1'b0;
					r.next_task = 4'(h);
				end
			end
		endcase
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH result %0d %s: got %0d want %0d", n_results, what, got, want);
		errors++;
	endtask

	function automatic cmd_t make_cmd(func_t f, int id, int p, reason_t rs,
	                                  logic [31:0] tv, logic fv);
		cmd_t c;
		c.func = f; c.task_id = 4'(id); c.task_priority_in = 8'(p);
		c.switch_reason = rs; c.time_value = tv; c.sleep_forever = fv;
		return c;
	endfunction

	function automatic cmd_t random_cmd(int window);
		cmd_t c;
		int k;
		c = make_cmd(func_t'($urandom_range(3)), int'($urandom_range(15)), 0,
		             reason_t'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
		c.task_priority_in = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
		k = int'($urandom_range(9));
		if (k < 6) c.time_value = 32'(window + int'($urandom_range(40)) - 10);
		else if (k == 6) c.time_value = 0;
		if (c.func == FUNC_READY && !sch_made[c.task_id]) c.func = FUNC_CREATE;
		return c;
	endfunction

	task automatic send(cmd_t c);
		while (send_gap > 0 && $urandom_range(99) < send_gap) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (!cmd_ready);
		expected_q.push_back(schedule(c));
	endtask

	always @(posedge clk) begin
		if (res_valid && res_ready) begin
			if (expected_q.size() == 0) begin
				report("arrived with nothing expected", 1, 0);
			end else begin
				res_t e;
				e = expected_q.pop_front();
				if (res.next_task !== e.next_task) report("next_task", res.next_task, e.next_task);
				if (res.next_is_idle !== e.next_is_idle)
					report("next_is_idle", res.next_is_idle, e.next_is_idle);
				if (res.preempt !== e.preempt)
					report("preempt", res.preempt, e.preempt);
			end
			n_results++;
		end
		res_ready <= !hold_off && !(recv_gap > 0 && $urandom_range(99) < recv_gap);
	end

	initial begin
		#100_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int window;
		cmd_t c;
		errors = 0; n_results = 0; send_gap = 0; recv_gap = 0; hold_off = 1'b0;
		arst_n = 1'b0; cmd_valid = 1'b0; cmd = '0; res_ready = 1'b0;
		sched_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_rows.push_back('{make_cmd(FUNC_SWITCH, 0, 0, RSN_READY, 0, 0), 1, 6'b0000_1_0});
		dir_rows.push_back('{make_cmd(FUNC_TICK, 0, 0, RSN_READY, 32'hFFFF_FFFF, 0), 1, '0});
		dir_rows.push_back('{make_cmd(FUNC_CREATE, 0, 0, RSN_READY, 0, 0), 1, '0});
		dir_rows.push_back('{make_cmd(FUNC_CREATE, 15, 255, RSN_SLEEP, 0, 1), 1, '0});
		dir_rows.push_back('{make_cmd(FUNC_CREATE, 7, 255, RSN_BUSY, 0, 0), 1, '0});
		dir_rows.push_back('{make_cmd(FUNC_SWITCH, 0, 0, RSN_READY, 0, 0), 1, 6'b1111_0_0});
		dir_rows.push_back('{make_cmd(FUNC_READY, 0, 0, RSN_READY, 0, 0), 0, '0});
		dir_rows.push_back('{make_cmd(FUNC_SWITCH, 0, 0, RSN_BUSY, 0, 0), 0, '0});
		dir_rows.push_back('{make_cmd(FUNC_SWITCH, 0, 0, RSN_SLEEP, 32'hFFFF_FFFF, 0), 0, '0});
		dir_rows.push_back('{make_cmd(FUNC_SWITCH, 0, 0, RSN_SLEEP, 0, 0), 0, '0});
		dir_rows.push_back('{make_cmd(FUNC_SWITCH, 0, 0, RSN_SYNC, 5, 0), 0, '0});
		dir_rows.push_back('{make_cmd(FUNC_SWITCH, 0, 0, RSN_SLEEP, 9, 1), 0, '0});
		dir_rows.push_back('{make_cmd(FUNC_TICK, 0, 0, RSN_READY, 32'hFFFF_FFFE, 0), 0, '0});
		dir_rows.push_back('{make_cmd(FUNC_TICK, 0, 0, RSN_READY, 32'hFFFF_FFFF, 0), 0, '0});
		dir_rows.push_back('{make_cmd(FUNC_READY, 15, 0, RSN_READY, 0, 0), 0, '0});
		dir_rows.push_back('{make_cmd(FUNC_READY, 7, 0, RSN_READY, 0, 0), 0, '0});
		dir_rows.push_back('{make_cmd(FUNC_SWITCH, 0, 0, RSN_SLEEP, 0, 1), 0, '0});
		dir_rows.push_back('{make_cmd(FUNC_SWITCH, 0, 0, RSN_SYNC, 0, 0), 0, '0});
		dir_rows.push_back('{make_cmd(FUNC_SWITCH, 0, 0, RSN_READY, 0, 0), 0, '0});
		dir_rows.push_back('{make_cmd(FUNC_SWITCH, 0, 0, RSN_READY, 0, 0), 0, '0});
		foreach (dir_rows[i]) begin
			send(dir_rows[i].c);
			if (dir_rows[i].chk && expected_q[$] !== dir_rows[i].r) begin
				report($sformatf("directed row %0d", i), 32'(expected_q[$]),
				       32'(dir_rows[i].r));
			end
		end

		window = 100;
		for (int phase = 0; phase < 3; phase++) begin
			send_gap = (phase == 0) ? 8 : (phase == 1) ? 47 : 0;
			recv_gap = (phase == 0) ? 47 : (phase == 1) ? 8 : 0;
			for (int i = 0; i < N_RANDOM / 3; i++) begin
				if (phase == 2 && i == 20) fork
					begin
						hold_off = 1'b1;
						repeat (400) @(posedge clk);
						hold_off = 1'b0;
					end
				join_none
				c = random_cmd(window);
				if (c.func == FUNC_TICK) window += $urandom_range(20);
				send(c);
			end
		end
		cmd_valid <= 1'b0;

		fork
			wait (expected_q.size() == 0);
			begin
				repeat (20000) @(posedge clk);
				$display("DONE: errors detected");
				$finish;
			end
		join_any
		disable fork;
		repeat (200) @(posedge clk);
		$display("Covered %0d results over create, ready, tick and switch commands,", n_results);
		$display("with idling on both channels and a long receiver stall.");
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
rtl/pts_pkg.sv
rtl/pts_cmp.sv
rtl/priority_task_scheduler.sv
verif/priority_task_scheduler_tb.sv
